// ===== rtl/sdcs_pkg.sv =====
// Package for the servo drive command sequencer.
// Holds the word structs, the mode/opcode/message codes and register reset values.
// No dependencies.
`default_nettype none

package sdcs_pkg;

  localparam int CFG_IDX_BITS = 2;
  localparam int CNT_BITS     = 32;

  localparam logic [CNT_BITS-1:0] SEARCH_RESET = 32'd2000000;
  localparam logic [CNT_BITS-1:0] OFFSET_RESET = 32'd5000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET = 2'd1;

  typedef enum logic [3:0] {
    OP_ENABLE    = 4'd0,
    OP_DISABLE   = 4'd1,
    OP_HOME      = 4'd2,
    OP_MOVE      = 4'd3,
    OP_MAX_LIMIT = 4'd4,
    OP_MIN_LIMIT = 4'd5,
    OP_ALARM     = 4'd6,
    OP_DONE      = 4'd7,
    OP_MALFORMED = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    MODE_INACTIVE  = 3'd0,
    MODE_ACTIVE    = 3'd1,
    MODE_HOME_FWD  = 3'd2,
    MODE_HOME_BACK = 3'd3,
    MODE_ON_DUTY   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    MSG_NONE   = 3'd0,
    MSG_ALARM  = 3'd1,
    MSG_READY  = 3'd2,
    MSG_NREADY = 3'd3,
    MSG_TPOS   = 3'd4,
    MSG_HOME   = 3'd5
  } msg_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_ZERO_DIST = 2'd2
  } err_t;

  localparam int LAMP_READY = 0;
  localparam int LAMP_TPOS  = 1;
  localparam int LAMP_HOME  = 2;
  localparam int LAMP_ALARM = 3;

  typedef struct packed {
    logic [3:0]          opcode;
    logic                from_bus;
    logic                direction;
    logic [CNT_BITS-1:0] distance_pulses;
    logic                drive_ready;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          message;
    logic                start_burst;
    logic [CNT_BITS-1:0] burst_pulses;
    logic                burst_forward;
    logic                search_speed;
    logic [2:0]          mode;
    logic                servo_on;
    logic                emergency;
    logic [3:0]          lamps;
    logic [1:0]          error;
  } out_word_t;

  typedef struct packed {
    mode_t      mode;
    logic       enable;
    logic       stop;
    logic [3:0] lamps;
    logic       dir;
    logic       slow;
  } drv_state_t;

endpackage

`default_nettype wire

// ===== rtl/servo_drive_command_sequencer.sv =====
// Top level of the servo drive command sequencer: input register, drive state,
// setup registers and result register. Depends on sdcs_pkg, sdcs_step, sdcs_outreg.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+-------------------------------
//   in       | in_valid / in_stall        | in_word  (in_word_t)
//   out      | out_valid / out_stall      | out_word (out_word_t)
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One word per cycle while out_stall is low. A word passes the input register,
// then the mode decision into the result register, where drive state updates too.
// rst (synchronous) sets mode inactive, lines and lamps low, setup regs to defaults.
// A stalled output holds its word; in_stall rises as soon as the input register
// holds a word that the stalled output cannot take. cfg_ready is always high.
`default_nettype none

module servo_drive_command_sequencer
  import sdcs_pkg::*;
#(
  parameter int PULSE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire in_word_t                in_word,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_word_t                    out_word,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CNT_BITS-1:0]     cfg_data
);

  logic                s1_valid;
  in_word_t            s1_word;
  drv_state_t          state;
  drv_state_t          state_next;
  out_word_t           result;
  logic [CNT_BITS-1:0] search_pulses;
  logic [CNT_BITS-1:0] offset_pulses;
  logic                can_load;
  logic                advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && can_load;
  assign in_stall  = s1_valid && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pulses <= SEARCH_RESET;
      offset_pulses <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEARCH: search_pulses <= cfg_data;
        REG_OFFSET: offset_pulses <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_INACTIVE, enable: 1'b0, stop: 1'b0, lamps: 4'b0,
                 dir: 1'b0, slow: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  sdcs_step #(
    .PULSE_BITS(PULSE_BITS)
  ) u_step (
    .search_pulses(search_pulses),
    .offset_pulses(offset_pulses),
    .item         (s1_word),
    .cur          (state),
    .nxt          (state_next),
    .result       (result)
  );

  sdcs_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_valid),
    .load_word(result),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // emergency stop stays latched until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    state.stop |=> state.stop)
    else $error("emergency line dropped");

  a_emerg_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.emergency |-> out_word.lamps[LAMP_ALARM])
    else $error("emergency without alarm lamp");

  a_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.start_burst |-> out_word.burst_pulses == '0)
    else $error("burst count without burst");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.error != ERR_NONE |->
      !out_word.start_burst && out_word.message == MSG_NONE)
    else $error("error word carries action");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("drive state moved without a word");

endmodule

`default_nettype wire

// ===== rtl/sdcs_step.sv =====
// Mode decision for one word: next drive state and the result word.
// Pure combinational; depends on sdcs_pkg.
`default_nettype none

module sdcs_step
  import sdcs_pkg::*;
#(
  parameter int PULSE_BITS = 32
) (
  input  wire logic [CNT_BITS-1:0] search_pulses,
  input  wire logic [CNT_BITS-1:0] offset_pulses,
  input  wire in_word_t            item,
  input  wire drv_state_t          cur,
  output drv_state_t               nxt,
  output out_word_t                result
);

  // largest count the pulse generator takes
  localparam logic [CNT_BITS-1:0] CNT_TOP = {CNT_BITS{1'b1}} >> (CNT_BITS - PULSE_BITS);

  logic                start;
  logic [CNT_BITS-1:0] cnt_raw;
  logic                fwd;
  logic                slow;
  msg_t                msg;
  err_t                err;
  logic                launch;

  always_comb begin
    nxt     = cur;
    start   = 1'b0;
    cnt_raw = '0;
    fwd     = cur.dir;
    slow    = cur.slow;
    msg     = MSG_NONE;
    err     = ERR_NONE;
    case (item.opcode)
      OP_ENABLE: begin
        if (cur.mode == MODE_INACTIVE && item.drive_ready) begin
          nxt.enable            = 1'b1;
          nxt.lamps[LAMP_READY] = 1'b1;
          nxt.mode              = MODE_ACTIVE;
          msg                   = MSG_READY;
        end
      end
      OP_DISABLE: begin
        if (cur.mode == MODE_ACTIVE || cur.mode == MODE_ON_DUTY) begin
          nxt.enable = 1'b0;
          nxt.lamps  = cur.lamps & (4'b1 << LAMP_ALARM);
          nxt.mode   = MODE_INACTIVE;
          msg        = MSG_NREADY;
        end
      end
      OP_HOME: begin
        if (cur.mode == MODE_ACTIVE || (item.from_bus && cur.mode == MODE_ON_DUTY)) begin
          nxt.mode = MODE_HOME_FWD;
          start    = 1'b1;
          cnt_raw  = search_pulses;
          fwd      = 1'b1;
          slow     = 1'b1;
        end
      end
      OP_MOVE: begin
        if (cur.mode == MODE_ON_DUTY) begin
          if (item.distance_pulses == '0) begin
            err = ERR_ZERO_DIST;
          end else begin
            start   = 1'b1;
            cnt_raw = item.distance_pulses;
            fwd     = item.direction;
          end
        end
      end
      OP_MAX_LIMIT, OP_MIN_LIMIT, OP_ALARM: begin
        if (cur.mode == MODE_ON_DUTY) begin
          nxt.stop              = 1'b1;
          nxt.lamps[LAMP_ALARM] = 1'b1;
          nxt.mode              = MODE_INACTIVE;
          msg                   = MSG_ALARM;
        end else if (item.opcode == OP_MAX_LIMIT && cur.mode == MODE_HOME_FWD) begin
          nxt.mode = MODE_HOME_BACK;
          start    = 1'b1;
          cnt_raw  = search_pulses;
          fwd      = 1'b0;
          slow     = 1'b1;
        end else if (item.opcode == OP_MIN_LIMIT && cur.mode == MODE_HOME_BACK) begin
          nxt.mode = MODE_ON_DUTY;
          start    = 1'b1;
          cnt_raw  = offset_pulses;
          fwd      = 1'b1;
          slow     = 1'b0;
          msg      = MSG_HOME;
        end
      end
      OP_DONE: begin
        if (cur.mode == MODE_ON_DUTY) begin
          nxt.lamps[LAMP_TPOS] = 1'b1;
          msg                  = MSG_TPOS;
        end
      end
      default: begin
        err = ERR_MALFORMED;
      end
    endcase

    launch = start;
    if (launch) begin
      // a new burst clears homed/target lamps; homed comes back on the offset burst
      nxt.lamps[LAMP_TPOS] = 1'b0;
      nxt.lamps[LAMP_HOME] = (msg == MSG_HOME);
      nxt.dir              = fwd;
      nxt.slow             = slow;
    end

    result.message       = msg;
    result.start_burst   = start;
    result.burst_pulses  = (cnt_raw > CNT_TOP) ? CNT_TOP : cnt_raw;
    result.burst_forward = nxt.dir;
    result.search_speed  = nxt.slow;
    result.mode          = nxt.mode;
    result.servo_on      = nxt.enable;
    result.emergency     = nxt.stop;
    result.lamps         = nxt.lamps;
    result.error         = err;
  end

endmodule

`default_nettype wire

// ===== rtl/sdcs_outreg.sv =====
// Result register for the output channel; loads when empty or when the word is taken.
// Depends on sdcs_pkg.
`default_nettype none

module sdcs_outreg
  import sdcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_word_t load_word,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_word <= load_word;
    end
  end

endmodule

`default_nettype wire
